[rtl/tun_pkg.sv]
`default_nettype none
package tun_pkg;

  // Normalized cross components keep 31 bits, top bit at position 30.
  localparam int CBITS = 31;
  localparam int SUMW  = 64;
  localparam int ROOTW = 32;
  localparam int OUTW  = 32;

  typedef struct packed {
    logic [2:0][CBITS-1:0] c;
    logic [2:0]            neg;
    logic                  deg;
  } side_t;

endpackage
`default_nettype wire

[rtl/tun_cross.sv]
`default_nettype none
module tun_cross #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [9*COORD_WIDTH-1:0]   in_vtx,
  output logic                            out_vld,
  output logic [3*(2*COORD_WIDTH+3)-1:0]  out_n
);
  localparam int EW = COORD_WIDTH + 1;
  localparam int H  = EW / 2;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;

  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [EW+H:0]  lo_r [6];
  logic signed [PW-H-1:0] hi_r [6];
  logic signed [PW-1:0]  pr_r [6];
  logic signed [NW-1:0]  n_r  [3];
  logic [3:0]            vld_r;

  logic signed [EW-1:0]  a_op [6];
  logic signed [EW-1:0]  b_op [6];

  always_comb begin
    a_op[0] = e1_r[1]; b_op[0] = e2_r[2];
    a_op[1] = e1_r[2]; b_op[1] = e2_r[1];
    a_op[2] = e1_r[2]; b_op[2] = e2_r[0];
    a_op[3] = e1_r[0]; b_op[3] = e2_r[2];
    a_op[4] = e1_r[0]; b_op[4] = e2_r[1];
    a_op[5] = e1_r[1]; b_op[5] = e2_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'($signed(in_vtx[(3+i)*COORD_WIDTH +: COORD_WIDTH]))
                 - EW'($signed(in_vtx[i*COORD_WIDTH +: COORD_WIDTH]));
        e2_r[i] <= EW'($signed(in_vtx[(6+i)*COORD_WIDTH +: COORD_WIDTH]))
                 - EW'($signed(in_vtx[i*COORD_WIDTH +: COORD_WIDTH]));
      end
      // Each product is split on its second operand into an unsigned low half
      // and a signed high part; the registered parts are then recombined into pr_r.
      for (int k = 0; k < 6; k++) begin
        lo_r[k] <= a_op[k] * $signed({1'b0, b_op[k][H-1:0]});
        hi_r[k] <= a_op[k] * $signed(b_op[k][EW-1:H]);
      end
      for (int k = 0; k < 6; k++) begin
        pr_r[k] <= (PW'(hi_r[k]) <<< H) + PW'(lo_r[k]);
      end
      for (int j = 0; j < 3; j++) begin
        n_r[j] <= NW'(pr_r[2*j]) - NW'(pr_r[2*j+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign out_vld = vld_r[3];
  assign out_n   = {n_r[2], n_r[1], n_r[0]};
endmodule
`default_nettype wire

[rtl/tun_norm.sv]
`default_nettype none
module tun_norm #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [3*(2*COORD_WIDTH+3)-1:0] in_n,
  output logic                            out_vld,
  output tun_pkg::side_t                  out_side,
  output logic [tun_pkg::SUMW-1:0]        out_sum
);
  import tun_pkg::*;

  localparam int NW = 2 * COORD_WIDTH + 3;
  localparam int MW = NW - 1;
  localparam int G  = (MW + 7) / 8;
  localparam int GW = G * 8;
  localparam int PB = $clog2(GW);
  localparam int SQW = 2 * CBITS;

  logic [MW-1:0]   mag1_r [3];
  logic [MW-1:0]   mag2_r [3];
  logic [MW-1:0]   mag3_r [3];
  logic [2:0]      neg1_r, neg2_r, neg3_r;
  logic [GW-1:0]   or1_r;
  logic [G-1:0]    nz2_r;
  logic [2:0]      pos2_r [G];
  logic [PB-1:0]   p3_r;
  logic            deg3_r;
  side_t           side4_r, side5_r, side6_r;
  logic [SQW-1:0]  sq5_r [3];
  logic [SUMW-1:0] sum6_r;
  logic [5:0]      vld_r;

  logic [MW-1:0]   mag_nxt [3];
  logic [G-1:0]    nz_nxt;
  logic [2:0]      pos_nxt [G];
  logic [PB-1:0]   p_nxt;
  logic            deg_nxt;
  logic [PB-1:0]   sh;
  logic [MW-1:0]   shifted [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_n[i*NW + NW-1]) begin
        mag_nxt[i] = MW'(-in_n[i*NW +: NW]);
      end else begin
        mag_nxt[i] = in_n[i*NW +: MW];
      end
    end
    for (int g = 0; g < G; g++) begin
      nz_nxt[g]  = |or1_r[g*8 +: 8];
      pos_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or1_r[g*8+b]) begin
          pos_nxt[g] = 3'(b);
        end
      end
    end
    p_nxt   = '0;
    deg_nxt = 1'b1;
    for (int g = 0; g < G; g++) begin
      if (nz2_r[g]) begin
        p_nxt   = PB'(g * 8) + PB'(pos2_r[g]);
        deg_nxt = 1'b0;
      end
    end
    // Shift the top set bit of the largest magnitude up to the word's MSB,
    // then keep the top CBITS bits: a right shift with truncation or an exact
    // left shift, whichever applies.
    sh = PB'(MW - 1) - p3_r;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = mag3_r[i] << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag_nxt[i];
        neg1_r[i] <= in_n[i*NW + NW-1];
      end
      or1_r  <= GW'(mag_nxt[0] | mag_nxt[1] | mag_nxt[2]);
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      nz2_r  <= nz_nxt;
      pos2_r <= pos_nxt;
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
      p3_r   <= p_nxt;
      deg3_r <= deg_nxt;
      for (int i = 0; i < 3; i++) begin
        side4_r.c[i] <= shifted[i][MW-1 -: CBITS];
      end
      side4_r.neg <= neg3_r;
      side4_r.deg <= deg3_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= side4_r.c[i] * side4_r.c[i];
      end
      side5_r <= side4_r;
      sum6_r  <= SUMW'(sq5_r[0]) + SUMW'(sq5_r[1]) + SUMW'(sq5_r[2]);
      side6_r <= side5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  assign out_vld  = vld_r[5];
  assign out_side = side6_r;
  assign out_sum  = sum6_r;
endmodule
`default_nettype wire

[rtl/tun_sqrt.sv]
`default_nettype none
module tun_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire tun_pkg::side_t           in_side,
  input  wire logic [tun_pkg::SUMW-1:0] in_sum,
  output logic                          out_vld,
  output tun_pkg::side_t                out_side,
  output logic [tun_pkg::ROOTW-1:0]     out_root
);
  import tun_pkg::*;

  localparam int K = SUMW / 2;

  logic [SUMW-1:0] x_st   [K+1];
  logic [SUMW-1:0] r_st   [K+1];
  side_t           side_st [K+1];
  logic            vld_st [K+1];

  assign x_st[0]    = in_sum;
  assign r_st[0]    = '0;
  assign side_st[0] = in_side;
  assign vld_st[0]  = in_vld;

  // One result bit per stage of the digit-by-digit square root.
  for (genvar k = 0; k < K; k++) begin : g_step
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (SUMW - 2 - 2 * k);
    logic [SUMW-1:0] trial;
    assign trial = r_st[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_st[k] >= trial) begin
          x_st[k+1] <= x_st[k] - trial;
          r_st[k+1] <= (r_st[k] >> 1) + BIT;
        end else begin
          x_st[k+1] <= x_st[k];
          r_st[k+1] <= r_st[k] >> 1;
        end
        side_st[k+1] <= side_st[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_st[k+1] <= 1'b0;
      end else if (en) begin
        vld_st[k+1] <= vld_st[k];
      end
    end
  end

  assign out_vld  = vld_st[K];
  assign out_side = side_st[K];
  assign out_root = r_st[K][ROOTW-1:0];
endmodule
`default_nettype wire

[rtl/tun_div.sv]
`default_nettype none
module tun_div #(
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire tun_pkg::side_t            in_side,
  input  wire logic [tun_pkg::ROOTW-1:0] in_root,
  output logic                           out_vld,
  output logic [3*tun_pkg::OUTW-1:0]     out_normal,
  output logic                           out_deg
);
  import tun_pkg::*;

  localparam int QB  = NORMAL_FRAC_BITS + 1;
  localparam int NMW = CBITS + NORMAL_FRAC_BITS + ROOTW;

  logic [NMW-1:0]   rem_st [QB+1][3];
  logic [QB-1:0]    q_st   [QB+1][3];
  logic [ROOTW-1:0] l_st   [QB+1];
  logic [2:0]       neg_st [QB+1];
  logic             deg_st [QB+1];
  logic             vld_st [QB+1];
  logic [3*OUTW-1:0] normal_r;
  logic             deg_r;
  logic             vld_r;

  // Numerator with half the divisor added, so the quotient rounds to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_st[0][i] <= (NMW'(in_side.c[i]) << NORMAL_FRAC_BITS) + NMW'(in_root >> 1);
        q_st[0][i]   <= '0;
      end
      l_st[0]   <= in_root;
      neg_st[0] <= in_side.neg;
      deg_st[0] <= in_side.deg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_st[0] <= 1'b0;
    end else if (en) begin
      vld_st[0] <= in_vld;
    end
  end

  // Restoring division, one quotient bit per stage from the top down.
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int B = QB - 1 - j;
    logic [NMW-1:0] dv;
    assign dv = NMW'(l_st[j]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_st[j][i] >= dv) begin
            rem_st[j+1][i] <= rem_st[j][i] - dv;
            q_st[j+1][i]   <= q_st[j][i] | (QB'(1) << B);
          end else begin
            rem_st[j+1][i] <= rem_st[j][i];
            q_st[j+1][i]   <= q_st[j][i];
          end
        end
        l_st[j+1]   <= l_st[j];
        neg_st[j+1] <= neg_st[j];
        deg_st[j+1] <= deg_st[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_st[j+1] <= 1'b0;
      end else if (en) begin
        vld_st[j+1] <= vld_st[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (deg_st[QB]) begin
          normal_r[i*OUTW +: OUTW] <= '0;
        end else if (neg_st[QB][i]) begin
          normal_r[i*OUTW +: OUTW] <= -OUTW'(q_st[QB][i]);
        end else begin
          normal_r[i*OUTW +: OUTW] <= OUTW'(q_st[QB][i]);
        end
      end
      deg_r <= deg_st[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_st[QB];
    end
  end

  assign out_vld    = vld_r;
  assign out_normal = normal_r;
  assign out_deg    = deg_r;
endmodule
`default_nettype wire

[rtl/triangle_unit_normal.sv]
`default_nettype none
// Unit face normal of one triangle per clock while the output is taken. A beat on the input stream
// carries three vertices; the block forms the edges from the first vertex,
// their exact cross product, scales it so the largest component has its top
// bit at bit 30, takes the square root of the sum of squares and divides each
// component by it, rounding to nearest. Results are signed Q1.30 with one at
// 2^NORMAL_FRAC_BITS. A triangle whose cross product is zero gives a zero
// normal with the degenerate flag (out_tuser) set. The pipeline runs through
// the cross product, the scaling and sum of squares, the square root and the
// divider, in that order. A new triangle is accepted every cycle; when the
// output is not taken the whole pipeline holds.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  // normal_x, normal_y, normal_z
  output logic [3*tun_pkg::OUTW-1:0] out_tdata,
  // degenerate
  output logic       out_tuser
);
  import tun_pkg::*;

  localparam int NW = 2 * COORD_WIDTH + 3;

  logic              en;
  logic              cr_vld;
  logic [3*NW-1:0]   cr_n;
  logic              nm_vld;
  side_t             nm_side;
  logic [SUMW-1:0]   nm_sum;
  logic              sq_vld;
  side_t             sq_side;
  logic [ROOTW-1:0]  sq_root;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid), .in_vtx(in_tdata[9*COORD_WIDTH-1:0]),
    .out_vld(cr_vld), .out_n(cr_n)
  );

  tun_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(cr_vld), .in_n(cr_n),
    .out_vld(nm_vld), .out_side(nm_side), .out_sum(nm_sum)
  );

  tun_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(nm_vld), .in_side(nm_side), .in_sum(nm_sum),
    .out_vld(sq_vld), .out_side(sq_side), .out_root(sq_root)
  );

  tun_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(sq_vld), .in_side(sq_side), .in_root(sq_root),
    .out_vld(out_tvalid), .out_normal(out_tdata), .out_deg(out_tuser)
  );
endmodule
`default_nettype wire

[tb/triangle_unit_normal_test.sv]
module triangle_unit_normal_test;

  typedef struct {
    logic [31:0] nx, ny, nz;
    logic        deg;
  } normal_t;

  class normal_board;
    normal_t pending[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    // Exact cross product, scaled so the largest magnitude has its top bit at 30,
    // then divided by the integer square root of the sum of squares.
    function normal_t face_normal(logic [287:0] tri_data);
      logic signed [63:0]  v[9];
      logic signed [63:0]  e1[3], e2[3];
      logic signed [127:0] n[3];
      logic [127:0]        mag[3];
      logic [127:0]        mx;
      logic [63:0]         c[3];
      logic [63:0]         s, len, q, bitv, x;
      logic [31:0]         res[3];
      normal_t             r;
      int                  p;
      for (int i = 0; i < 9; i++) v[i] = {{32{tri_data[32*i+31]}}, tri_data[32*i +: 32]};
      for (int i = 0; i < 3; i++) begin
        e1[i] = v[3+i] - v[i];
        e2[i] = v[6+i] - v[i];
      end
      n[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
      n[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
      n[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = n[i][127] ? -n[i] : n[i];
        if (mag[i] > mx) mx = mag[i];
      end
      p = -1;
      for (int b = 0; b < 128; b++) if (mx[b]) p = b;
      if (p < 0) begin
        r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 1'b1;
        return r;
      end
      for (int i = 0; i < 3; i++)
        c[i] = (p >= 30) ? 64'(mag[i] >> (p - 30)) : 64'(mag[i] << (30 - p));
      s = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      x = s; len = 0; bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= len + bitv) begin
          x -= len + bitv;
          len = (len >> 1) + bitv;
        end else begin
          len >>= 1;
        end
        bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = ((c[i] << 30) + (len >> 1)) / len;
        if (n[i][127]) q = -q;
        res[i] = q[31:0];
      end
      r.nx = res[0]; r.ny = res[1]; r.nz = res[2]; r.deg = 1'b0;
      return r;
    endfunction

    function void note_triangle(logic [287:0] tri_data);
      pending.push_back(face_normal(tri_data));
    endfunction

    function void check_normal(logic [95:0] data, logic deg);
      normal_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h deg %b", $time, data, deg);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.nx) begin
        $display("%0t: normal_x expected %h actual %h", $time, want.nx, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.ny) begin
        $display("%0t: normal_y expected %h actual %h", $time, want.ny, data[63:32]);
        errors++;
      end
      if (data[95:64] !== want.nz) begin
        $display("%0t: normal_z expected %h actual %h", $time, want.nz, data[95:64]);
        errors++;
      end
      if (deg !== want.deg) begin
        $display("%0t: degenerate expected %b actual %b", $time, want.deg, deg);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;

  normal_board board = new();
  int          send_idle = 0;
  int          recv_idle = 0;
  int          cycles = 0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("triangle_unit_normal regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_normal(out_tdata, out_tuser);
    if (rst_n && in_tvalid && in_tready) board.note_triangle(in_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Drives one triangle beat; valid stays high across back-to-back beats.
  task automatic send_triangle(logic [287:0] tri_data);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tri_data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  function automatic logic [287:0] rand_triangle();
    logic [287:0] t;
    int           mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 9; i++) t[32*i +: 32] = rand_coord($urandom_range(9) == 0 ? 3 : mode);
    // Now and then collapse the second or third vertex onto the first.
    case ($urandom_range(9))
      0: t[191:96] = t[95:0];
      1: for (int i = 0; i < 3; i++) t[192+32*i +: 32] = t[32*i +: 32];
      default: ;
    endcase
    return t;
  endfunction

  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    logic [287:0] t;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit axes, extremes, degenerate shapes, tiny triangles.
    send_triangle({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0});
    send_triangle({ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0});
    send_triangle({32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_triangle({32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_triangle('0);
    send_triangle({3{MAXC, MINC, MAXC}});
    send_triangle({32'd2, 32'd2, 32'd2, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0});
    send_triangle({MAXC, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC});
    send_triangle({MINC, MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC});
    send_triangle({MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MINC, MAXC});
    send_triangle({32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
    send_triangle({32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_triangle({32'hffff_ffff, 32'd3, 32'd7, 32'd5, 32'hffff_fff0, 32'd1,
                   32'd9, 32'd2, 32'hffff_fffe});
    send_triangle({9{32'hffff_ffff}});
    send_triangle({9{32'h5555_5555}});
    send_triangle({MAXC, 32'd0, 32'd0, 32'd0, MAXC, 32'd0, 32'd0, 32'd0, MAXC});
    go_quiet();

    // The sender holds off until the pipeline drains completely.
    while (board.pending.size() != 0) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 86 : 0;
      recv_idle = (phase == 0) ? 86 : (phase == 1) ? 38 : 0;
      for (int k = 0; k < 212; k++) begin
        t = rand_triangle();
        send_triangle(t);
      end
      go_quiet();
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("triangle_unit_normal regression: pass");
    else
      $display("triangle_unit_normal regression: fail");
    $finish;
  end

endmodule

[triangle_unit_normal.f]
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_norm.sv
rtl/tun_sqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal.sv
tb/triangle_unit_normal_test.sv
